@@ rtl/sfx_pkg.sv @@
`default_nettype none
package sfx_pkg;

    localparam int ValueW = 16;
    localparam int ProbW  = 16;
    localparam int PosW   = 6;
    localparam int SumW   = 22;
    localparam int AccW   = 33;
    localparam int ExpCut = 4095;
    localparam int SeriesTerms = 24;

    typedef logic [AccW-1:0] exp_tab_t [256];

    typedef struct packed {
        logic start;
    } sfx_token_t;

    typedef enum logic [1:0] {
        F_LOAD,
        F_EMIT,
        F_WAIT
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SUM_RD,
        B_SUM_K,
        B_SUM_WAIT,
        B_EM_RD,
        B_EM_K,
        B_EM_WAIT,
        B_DIV,
        B_OUT
    } back_state_t;

    // restoring long division, only ever evaluated on constants
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-r/256) in Q1.32, taylor series on a Q10.54 term
    function automatic logic [AccW-1:0] exp_neg_q32(input int unsigned r);
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] rr;
        t = 64'd1 << 54;
        s = t;
        for (int n = 1; n <= SeriesTerms; n++)
        begin
            t = udiv64(t * 64'(r), 64'd256 * 64'(n));
            if (n[0] == 1'b1)
                s = s - t;
            else
                s = s + t;
        end
        rr = (s + (64'd1 << 21)) >> 22;
        return rr[AccW-1:0];
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = exp_neg_q32(i);
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();
    localparam logic [AccW-1:0] EXP_E1 = exp_neg_q32(256);

endpackage
`default_nettype wire

@@ rtl/sfx_ram.sv @@
`default_nettype none
module sfx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/sfx_fifo.sv @@
`default_nettype none
module sfx_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire sfx_pkg::sfx_token_t push_data,
    input  wire logic              pop,
    output sfx_pkg::sfx_token_t    pop_data,
    output logic                   empty,
    output logic                   full
);
    import sfx_pkg::*;

    localparam int PW = $clog2(DEPTH);

    sfx_token_t        slot_reg [DEPTH];
    logic [PW-1:0]     wr_reg;
    logic [PW-1:0]     rd_reg;
    logic [PW:0]       cnt_reg;

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == (PW+1)'(DEPTH));
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sfx_front.sv @@
`default_nettype none
module sfx_front #(
    parameter int VEC_MAX = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic signed [15:0]          value,
    input  wire logic                        last,
    input  wire logic                        fifo_empty,
    input  wire logic                        fifo_full,
    input  wire logic                        back_idle,
    output logic                             push,
    output sfx_pkg::sfx_token_t              push_data,
    output logic                             ram_we,
    output logic [$clog2(VEC_MAX)-1:0]       ram_waddr,
    output logic [15:0]                      ram_wdata,
    output logic [$clog2(VEC_MAX+1)-1:0]     count,
    output logic signed [15:0]               vmax,
    output logic                             dropped
);
    import sfx_pkg::*;

    localparam int AW = $clog2(VEC_MAX);
    localparam int CW = $clog2(VEC_MAX+1);

    front_state_t       state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      remain_reg, remain_next;
    logic signed [15:0] max_reg, max_next;
    logic               drop_reg, drop_next;
    logic               accept;

    assign count     = count_reg;
    assign vmax      = max_reg;
    assign dropped   = drop_reg;
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = value;
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_LOAD;
            count_reg  <= '0;
            remain_reg <= '0;
            max_reg    <= 16'sh8000;
            drop_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            max_reg    <= max_next;
            drop_reg   <= drop_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        max_next         = max_reg;
        drop_next        = drop_reg;
        in_stall         = 1'b1;
        push             = 1'b0;
        push_data.start  = 1'b0;
        ram_we           = 1'b0;
        unique case (state_reg)
            F_LOAD:
            begin
                // the store and vector state belong to the back end until it drains
                in_stall = !(fifo_empty && back_idle);
                if (accept)
                begin
                    if (count_reg < CW'(VEC_MAX))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (value > max_reg)
                            max_next = value;
                    end
                    else
                        drop_next = 1'b1;
                    if (last)
                    begin
                        push            = 1'b1;
                        push_data.start = 1'b1;
                        remain_next     = count_next - 1'b1;
                        state_next      = (count_next == CW'(1)) ? F_WAIT : F_EMIT;
                    end
                end
            end
            F_EMIT:
            begin
                in_stall = fifo_full;
                if (accept)
                begin
                    push        = 1'b1;
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CW'(1))
                        state_next = F_WAIT;
                end
            end
            F_WAIT:
            begin
                if (fifo_empty && back_idle)
                begin
                    count_next = '0;
                    max_next   = 16'sh8000;
                    drop_next  = 1'b0;
                    state_next = F_LOAD;
                end
            end
            default:
            begin
                state_next = F_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/sfx_exp.sv @@
`default_nettype none
module sfx_exp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] k,
    output logic             done,
    output logic [15:0]      e
);
    import sfx_pkg::*;

    logic [AccW-1:0]   acc_reg;
    logic [3:0]        q_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [15:0]       e_reg;
    logic [64:0]       prod;
    logic [48:0]       scaled;

    assign prod   = 65'(acc_reg) * 65'(EXP_E1);
    // acc * 65535 as a shift and subtract
    assign scaled = {acc_reg, 16'd0} - 49'(acc_reg);
    assign done   = done_reg;
    assign e      = e_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            if (k > 16'(ExpCut))
            begin
                acc_reg <= '0;
                q_reg   <= '0;
            end
            else
            begin
                acc_reg <= EXP_TAB[k[7:0]];
                q_reg   <= k[11:8];
            end
        end
        else if (busy_reg && q_reg != '0)
        begin
            acc_reg <= prod[AccW+31:32];
            q_reg   <= q_reg - 1'b1;
        end
        if (busy_reg && q_reg == '0)
            e_reg <= scaled[47:32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && q_reg == '0 && !start;
            if (start)
                busy_reg <= 1'b1;
            else if (q_reg == '0)
                busy_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sfx_back.sv @@
`default_nettype none
module sfx_back #(
    parameter int VEC_MAX = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fifo_empty,
    input  wire sfx_pkg::sfx_token_t         pop_data,
    output logic                             pop,
    output logic                             idle,
    input  wire logic [$clog2(VEC_MAX+1)-1:0] count,
    input  wire logic signed [15:0]          vmax,
    input  wire logic                        dropped,
    output logic [$clog2(VEC_MAX)-1:0]       ram_raddr,
    input  wire logic [15:0]                 ram_rdata,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [15:0]                      prob,
    output logic [5:0]                       position,
    output logic                             last_out,
    output logic                             overflow
);
    import sfx_pkg::*;

    localparam int AW = $clog2(VEC_MAX);
    localparam int CW = $clog2(VEC_MAX+1);

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [SumW-1:0]   sum_reg, sum_next;
    logic [31:0]       num_reg, num_next;
    logic [SumW-1:0]   rem_reg, rem_next;
    logic [15:0]       quo_reg, quo_next;
    logic [3:0]        bit_reg, bit_next;
    logic              ov_reg, ov_next;
    logic [15:0]       prob_reg, prob_next;
    logic [5:0]        pos_reg, pos_next;
    logic              lo_reg, lo_next;
    logic              of_reg, of_next;

    logic              exp_start;
    logic              exp_done;
    logic [15:0]       exp_e;
    logic [16:0]       diff;
    logic [SumW:0]     rem_sh;
    logic [SumW:0]     rem_sub;
    logic              is_final;
    logic              out_free;

    assign diff      = {vmax[15], vmax} - {ram_rdata[15], ram_rdata};
    assign rem_sh    = {rem_reg, num_reg[bit_reg]};
    assign rem_sub   = rem_sh - (SumW+1)'(sum_reg);
    assign is_final  = (CW'(idx_reg) + 1'b1 == count);
    assign out_free  = !ov_reg || !out_stall;
    assign ram_raddr = idx_reg;
    assign idle      = (state_reg == B_IDLE);
    assign out_valid = ov_reg;
    assign prob      = prob_reg;
    assign position  = pos_reg;
    assign last_out  = lo_reg;
    assign overflow  = of_reg;

    sfx_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (exp_start),
        .k     (diff[15:0]),
        .done  (exp_done),
        .e     (exp_e)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        prob_reg <= prob_next;
        pos_reg  <= pos_next;
        lo_reg   <= lo_next;
        of_reg   <= of_next;
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        prob_next  = prob_reg;
        pos_next   = pos_reg;
        lo_next    = lo_reg;
        of_next    = of_reg;
        ov_next    = ov_reg && out_stall;
        pop        = 1'b0;
        exp_start  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop = 1'b1;
                    if (pop_data.start)
                    begin
                        sum_next   = '0;
                        idx_next   = '0;
                        state_next = B_SUM_RD;
                    end
                    else
                        state_next = B_EM_RD;
                end
            end
            B_SUM_RD:
            begin
                state_next = B_SUM_K;
            end
            B_SUM_K:
            begin
                exp_start  = 1'b1;
                state_next = B_SUM_WAIT;
            end
            B_SUM_WAIT:
            begin
                if (exp_done)
                begin
                    sum_next = sum_reg + SumW'(exp_e);
                    if (is_final)
                    begin
                        idx_next   = '0;
                        state_next = B_EM_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = B_SUM_RD;
                    end
                end
            end
            B_EM_RD:
            begin
                state_next = B_EM_K;
            end
            B_EM_K:
            begin
                exp_start  = 1'b1;
                state_next = B_EM_WAIT;
            end
            B_EM_WAIT:
            begin
                if (exp_done)
                begin
                    // e * 65535, quotient fits 16 bits so the top half starts the remainder
                    num_next   = {exp_e, 16'd0} - 32'(exp_e);
                    rem_next   = SumW'(num_next[31:16]);
                    quo_next   = '0;
                    bit_next   = 4'd15;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (!rem_sub[SumW])
                begin
                    rem_next = rem_sub[SumW-1:0];
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[SumW-1:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    prob_next  = quo_reg;
                    pos_next   = PosW'(idx_reg);
                    lo_next    = is_final;
                    of_next    = dropped;
                    idx_next   = is_final ? '0 : idx_reg + 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/softmax_vector_unit.sv @@
`default_nettype none
// channel  signals                            direction
// input    in_valid, in_stall, value, last    in (in_stall out)
// output   out_valid, out_stall, prob,        out (out_stall in)
//          position, last_out, overflow
//
// loading takes one cycle per element while in_stall is low; the element marked last
// starts a sum pass that runs the exp for each element: a table lookup, then q
// multiplies by exp(-1), one per cycle (q = integer part of max - x, up to 15, zero
// past the cutoff); then each probability costs that exp again, a restoring division
// and an output step held by out_stall; each later one also pops its queue token.
// reset is asynchronous, active low, and returns to an empty vector.
// in_stall is high until the back end drains the previous vector, and while the
// queue is full during emission.
module softmax_vector_unit #(
    parameter int VEC_MAX = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] value,
    input  wire logic               last,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             prob,
    output logic [5:0]              position,
    output logic                    last_out,
    output logic                    overflow
);
    import sfx_pkg::*;

    localparam int AW = $clog2(VEC_MAX);
    localparam int CW = $clog2(VEC_MAX+1);

    sfx_token_t          push_data;
    sfx_token_t          pop_data;
    logic                push;
    logic                pop;
    logic                fifo_empty;
    logic                fifo_full;
    logic                back_idle;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [15:0]         ram_wdata;
    logic [15:0]         ram_rdata;
    logic [CW-1:0]       count;
    logic signed [15:0]  vmax;
    logic                dropped;

    sfx_front #(.VEC_MAX(VEC_MAX)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .last       (last),
        .fifo_empty (fifo_empty),
        .fifo_full  (fifo_full),
        .back_idle  (back_idle),
        .push       (push),
        .push_data  (push_data),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .count      (count),
        .vmax       (vmax),
        .dropped    (dropped)
    );

    sfx_ram #(.WIDTH(16), .DEPTH(VEC_MAX)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfx_fifo #(.DEPTH(4)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    sfx_back #(.VEC_MAX(VEC_MAX)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .idle       (back_idle),
        .count      (count),
        .vmax       (vmax),
        .dropped    (dropped),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prob       (prob),
        .position   (position),
        .last_out   (last_out),
        .overflow   (overflow)
    );

endmodule
`default_nettype wire
